@@ sv/lmfe_pkg.sv @@
`timescale 1ns / 1ps

package lmfe_pkg;

  localparam int MAX_DATA_BYTES = 8;
  localparam int LEN_W = 4;
  localparam int STEP_W = 4;
  localparam int IDX_W = 3;

  localparam logic [2:0] CMD_READ = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_RX_BYTE = 3'd2;
  localparam logic [2:0] CMD_TX_EMPTY = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  localparam logic [1:0] KIND_BREAK = 2'd0;
  localparam logic [1:0] KIND_TX = 2'd1;
  localparam logic [1:0] KIND_RX = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] MODE_STATUS = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_RXDATA = 2'd3;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [15:0] TIMEOUT_RESET = 16'd255;

  typedef struct packed {
    logic accept;
    logic load;
    logic last;
    logic [STEP_W-1:0] step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] last_step;
  } dp_status_t;

  function automatic logic [7:0] wrap_add(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, s} + {1'b0, b};
    return sum[7:0] + {7'd0, sum[8]};
  endfunction

  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

@@ sv/lin_master_frame_engine_top.sv @@
`timescale 1ns / 1ps

// LIN master frame engine: each input beat is one command (start read, start write, received
// byte, transmit FIFO empty, tick) and yields one or more result beats, one per cycle unless
// out_ready stalls the output, the last marked by last. A write with eight data bytes yields
// twelve results and a status-only command one; the result sequencer handles one command at
// a time, and the next command is taken while the final result of the previous one still
// waits in the output register. Every result of a command carries the receiver and
// transmitter status after that command.

module lin_master_frame_engine_top import lmfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [5:0]  frame_id,
  input  logic [3:0]  length,
  input  logic [7:0]  byte_in,
  input  logic [7:0]  data_0,
  input  logic [7:0]  data_1,
  input  logic [7:0]  data_2,
  input  logic [7:0]  data_3,
  input  logic [7:0]  data_4,
  input  logic [7:0]  data_5,
  input  logic [7:0]  data_6,
  input  logic [7:0]  data_7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  byte_out,
  output logic [2:0]  byte_index,
  output logic        refused,
  output logic        rx_empty,
  output logic        rx_complete,
  output logic        rx_busy,
  output logic        checksum_error,
  output logic        timeout_error,
  output logic        tx_busy,
  output logic        last
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  lmfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  lmfe_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .dp_status      (dp_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .command        (command),
    .frame_id       (frame_id),
    .length         (length),
    .byte_in        (byte_in),
    .data_0         (data_0),
    .data_1         (data_1),
    .data_2         (data_2),
    .data_3         (data_3),
    .data_4         (data_4),
    .data_5         (data_5),
    .data_6         (data_6),
    .data_7         (data_7),
    .kind           (kind),
    .byte_out       (byte_out),
    .byte_index     (byte_index),
    .refused        (refused),
    .rx_empty       (rx_empty),
    .rx_complete    (rx_complete),
    .rx_busy        (rx_busy),
    .checksum_error (checksum_error),
    .timeout_error  (timeout_error),
    .tx_busy        (tx_busy),
    .last           (last)
  );

endmodule

@@ sv/lmfe_ctrl.sv @@
`timescale 1ns / 1ps

module lmfe_ctrl import lmfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t dp_status,
  output ctrl_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic out_valid_next;
  logic can_load;
  logic is_last;

  assign in_ready = (state == ST_IDLE);
  assign can_load = (state == ST_EMIT) && (!out_valid || out_ready);
  assign is_last = (step == dp_status.last_step);

  assign cmd.accept = in_valid && in_ready;
  assign cmd.load = can_load;
  assign cmd.last = is_last;
  assign cmd.step = step;

  always_comb begin
    state_next = state;
    step_next = step;
    out_valid_next = out_valid;
    if (out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_next = ST_EMIT;
          step_next = '0;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          if (is_last) begin
            state_next = ST_IDLE;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ sv/lmfe_datapath.sv @@
`timescale 1ns / 1ps

module lmfe_datapath import lmfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  dp_status,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [2:0]  command,
  input  logic [5:0]  frame_id,
  input  logic [3:0]  length,
  input  logic [7:0]  byte_in,
  input  logic [7:0]  data_0,
  input  logic [7:0]  data_1,
  input  logic [7:0]  data_2,
  input  logic [7:0]  data_3,
  input  logic [7:0]  data_4,
  input  logic [7:0]  data_5,
  input  logic [7:0]  data_6,
  input  logic [7:0]  data_7,
  output logic [1:0]  kind,
  output logic [7:0]  byte_out,
  output logic [2:0]  byte_index,
  output logic        refused,
  output logic        rx_empty,
  output logic        rx_complete,
  output logic        rx_busy,
  output logic        checksum_error,
  output logic        timeout_error,
  output logic        tx_busy,
  output logic        last
);

  logic [15:0] timeout_ticks;

  logic st_empty;
  logic st_complete;
  logic st_busy;
  logic st_sumerr;
  logic st_timeout;
  logic tx_pending;
  logic header_pending;
  logic [1:0] echo_phase;
  logic [LEN_W-1:0] rx_index;
  logic [LEN_W-1:0] frame_len;
  logic [7:0] running_sum;
  logic [15:0] timeout_left;

  logic [1:0] mode;
  logic [7:0] pid;
  logic [7:0] rx_byte;
  logic [IDX_W-1:0] rx_idx;
  logic [LEN_W-1:0] wlen;
  logic [7:0] wdata [MAX_DATA_BYTES];
  logic refused_q;
  logic [7:0] tx_sum;

  logic [LEN_W-1:0] len_clamped;
  logic [7:0] pid_in;
  logic req_ok;
  logic is_req;

  logic [1:0] slot_kind;
  logic [7:0] slot_byte;
  logic [IDX_W-1:0] slot_idx;
  logic slot_is_data;
  logic [STEP_W-1:0] data_pos;
  logic [IDX_W-1:0] data_sel;

  assign len_clamped = (length > LEN_W'(MAX_DATA_BYTES)) ? LEN_W'(MAX_DATA_BYTES) : length;
  assign pid_in = make_pid(frame_id);
  assign is_req = (command == CMD_READ) || (command == CMD_WRITE);
  assign req_ok = st_empty && !tx_pending && !header_pending;

  always_comb begin
    case (mode)
      MODE_READ:  dp_status.last_step = STEP_W'(2);
      MODE_WRITE: dp_status.last_step = STEP_W'(3) + STEP_W'(wlen);
      default:    dp_status.last_step = '0;
    endcase
  end

  assign data_pos = cmd.step - STEP_W'(3);
  assign data_sel = data_pos[IDX_W-1:0];

  always_comb begin
    slot_kind = KIND_STATUS;
    slot_byte = 8'd0;
    slot_idx = '0;
    slot_is_data = 1'b0;
    case (mode)
      MODE_READ, MODE_WRITE: begin
        if (cmd.step == STEP_W'(0)) begin
          slot_kind = KIND_BREAK;
        end else if (cmd.step == STEP_W'(1)) begin
          slot_kind = KIND_TX;
          slot_byte = SYNC_BYTE;
        end else if (cmd.step == STEP_W'(2)) begin
          slot_kind = KIND_TX;
          slot_byte = pid;
        end else if (data_pos < STEP_W'(wlen)) begin
          slot_kind = KIND_TX;
          slot_byte = wdata[data_sel];
          slot_is_data = 1'b1;
        end else begin
          slot_kind = KIND_TX;
          slot_byte = ~tx_sum;
        end
      end
      MODE_RXDATA: begin
        slot_kind = KIND_RX;
        slot_byte = rx_byte;
        slot_idx = rx_idx;
      end
      default: begin
        slot_kind = KIND_STATUS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_empty <= 1'b1;
      st_complete <= 1'b0;
      st_busy <= 1'b0;
      st_sumerr <= 1'b0;
      st_timeout <= 1'b0;
      tx_pending <= 1'b0;
      header_pending <= 1'b0;
      echo_phase <= '0;
      rx_index <= '0;
      frame_len <= '0;
      running_sum <= '0;
      timeout_left <= '0;
      mode <= MODE_STATUS;
    end else if (cmd.accept) begin
      mode <= MODE_STATUS;
      case (command)
        CMD_READ: begin
          if (req_ok) begin
            mode <= MODE_READ;
            running_sum <= pid_in;
            frame_len <= len_clamped;
            rx_index <= '0;
            echo_phase <= '0;
            st_empty <= 1'b0;
            st_complete <= 1'b0;
            st_busy <= 1'b1;
            timeout_left <= timeout_ticks;
            header_pending <= 1'b1;
          end
        end
        CMD_WRITE: begin
          if (req_ok) begin
            mode <= MODE_WRITE;
            header_pending <= 1'b1;
            tx_pending <= 1'b1;
          end
        end
        CMD_RX_BYTE: begin
          if (st_busy) begin
            if (echo_phase < 2'd2) begin
              echo_phase <= echo_phase + 1'b1;
            end else if (rx_index < frame_len) begin
              mode <= MODE_RXDATA;
              running_sum <= wrap_add(running_sum, byte_in);
              rx_index <= rx_index + 1'b1;
            end else if (~running_sum == byte_in) begin
              st_busy <= 1'b0;
              st_sumerr <= 1'b0;
              st_timeout <= 1'b0;
              st_complete <= 1'b1;
              st_empty <= 1'b1;
            end else begin
              st_busy <= 1'b0;
              st_complete <= 1'b0;
              st_empty <= 1'b1;
              st_sumerr <= 1'b1;
            end
          end
        end
        CMD_TX_EMPTY: begin
          header_pending <= 1'b0;
          tx_pending <= 1'b0;
        end
        CMD_TICK: begin
          if (st_busy) begin
            if (timeout_left <= 16'd1) begin
              timeout_left <= '0;
              st_busy <= 1'b0;
              st_complete <= 1'b0;
              st_empty <= 1'b1;
              st_timeout <= 1'b1;
            end else begin
              timeout_left <= timeout_left - 1'b1;
            end
          end
        end
        default: begin
          mode <= MODE_STATUS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pid <= pid_in;
      tx_sum <= pid_in;
      rx_byte <= byte_in;
      rx_idx <= rx_index[IDX_W-1:0];
      wlen <= len_clamped;
      refused_q <= is_req && !req_ok;
      wdata[0] <= data_0;
      wdata[1] <= data_1;
      wdata[2] <= data_2;
      wdata[3] <= data_3;
      wdata[4] <= data_4;
      wdata[5] <= data_5;
      wdata[6] <= data_6;
      wdata[7] <= data_7;
    end else if (cmd.load && slot_is_data) begin
      tx_sum <= wrap_add(tx_sum, slot_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= slot_kind;
      byte_out <= slot_byte;
      byte_index <= slot_idx;
      refused <= refused_q;
      rx_empty <= st_empty;
      rx_complete <= st_complete;
      rx_busy <= st_busy;
      checksum_error <= st_sumerr;
      timeout_error <= st_timeout;
      tx_busy <= tx_pending;
      last <= cmd.last;
    end
  end

endmodule
